>>> hw/rtl/abcm_pkg.sv
// abcm_pkg: shared types, register indexes and the divide-by-255 helper
// for the ARGB blend unit. No dependencies.
`default_nettype none

package abcm_pkg;

  localparam int PIX_W   = 32;
  localparam int CH_W    = 8;
  localparam int PROD_W  = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOD_RED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_GREEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_BLUE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_ALPHA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_EN   = 3'd4;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            blend;
  } mod_t;

  // modulated source channels plus the untouched destination
  typedef struct packed {
    logic [CH_W-1:0]  a;
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic [PIX_W-1:0] dst;
  } scaled_t;

  // floor(x/255), exact for x <= 255*255
  function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + {{(PROD_W-CH_W+1){1'b0}}, x[PROD_W-1:CH_W]} + 17'd1;
    return t[PROD_W-1:CH_W];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/abcm_if.sv
// abcm channel interfaces: pixel input, result output, config write.
// Depends on abcm_pkg.
`default_nettype none

interface abcm_pix_if;
  import abcm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] src_pixel;
  logic [PIX_W-1:0] dst_pixel;
  modport source (output valid, src_pixel, dst_pixel, input ready);
  modport sink   (input valid, src_pixel, dst_pixel, output ready);
endinterface

interface abcm_out_if;
  import abcm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             write_enable;
  modport source (output valid, out_pixel, write_enable, input ready);
  modport sink   (input valid, out_pixel, write_enable, output ready);
endinterface

interface abcm_cfg_if;
  import abcm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CH_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/abcm_scale.sv
// abcm_scale: stages 1-2, per-channel modulation x*m/255.
// Depends on abcm_pkg.
`default_nettype none

module abcm_scale (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output      logic                    in_ready,
  input  wire logic [31:0]             src_pixel,
  input  wire logic [31:0]             dst_pixel,
  input  wire abcm_pkg::mod_t          mods,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      abcm_pkg::scaled_t       out_data
);
  import abcm_pkg::*;

  logic              v1;
  logic              v2;
  logic              ready1;
  logic              ready2;
  logic [PROD_W-1:0] pa, pr, pg, pb;
  logic [PIX_W-1:0]  dst1;
  scaled_t           s2;

  assign ready2   = !v2 || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
    if (ready1 && in_valid) begin
      pa   <= {8'd0, src_pixel[31:24]} * {8'd0, mods.alpha};
      pr   <= {8'd0, src_pixel[23:16]} * {8'd0, mods.red};
      pg   <= {8'd0, src_pixel[15:8]}  * {8'd0, mods.green};
      pb   <= {8'd0, src_pixel[7:0]}   * {8'd0, mods.blue};
      dst1 <= dst_pixel;
    end
  end

  // stage 2: divide by 255
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
    if (ready2 && v1) begin
      s2.a   <= div255(pa);
      s2.r   <= div255(pr);
      s2.g   <= div255(pg);
      s2.b   <= div255(pb);
      s2.dst <= dst1;
    end
  end

  assign out_valid = v2;
  assign out_data  = s2;

endmodule

`default_nettype wire

>>> hw/rtl/abcm_mix.sv
// abcm_mix: stages 3-4, source-over mix and output select.
// Depends on abcm_pkg.
`default_nettype none

module abcm_mix (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire abcm_pkg::scaled_t   in_data,
  input  wire logic                blend,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [31:0]         out_pixel,
  output      logic                write_enable
);
  import abcm_pkg::*;

  logic              v3;
  logic              v4;
  logic              ready3;
  logic              ready4;
  logic [CH_W-1:0]   inv;
  logic [PROD_W-1:0] ps_r, ps_g, ps_b;
  logic [PROD_W-1:0] pd_r, pd_g, pd_b, pd_a;
  scaled_t           s3;
  logic              transp3;
  logic              copy3;
  logic [PROD_W-1:0] sum_r, sum_g, sum_b;
  logic [CH_W-1:0]   alpha_mix;
  logic [PIX_W-1:0]  pix_next;

  assign ready4   = !v4 || out_ready;
  assign ready3   = !v3 || ready4;
  assign in_ready = ready3;
  assign inv      = CH_MAX - in_data.a;

  // stage 3: mix products and path select
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= in_valid;
    end
    if (ready3 && in_valid) begin
      ps_r    <= {8'd0, in_data.r} * {8'd0, in_data.a};
      ps_g    <= {8'd0, in_data.g} * {8'd0, in_data.a};
      ps_b    <= {8'd0, in_data.b} * {8'd0, in_data.a};
      pd_r    <= {8'd0, in_data.dst[23:16]} * {8'd0, inv};
      pd_g    <= {8'd0, in_data.dst[15:8]}  * {8'd0, inv};
      pd_b    <= {8'd0, in_data.dst[7:0]}   * {8'd0, inv};
      pd_a    <= {8'd0, in_data.dst[31:24]} * {8'd0, inv};
      s3      <= in_data;
      transp3 <= (in_data.a == 8'd0);
      copy3   <= !blend || (in_data.a == CH_MAX);
    end
  end

  // sums stay <= 255*255, so 16 bits hold them
  assign sum_r     = ps_r + pd_r;
  assign sum_g     = ps_g + pd_g;
  assign sum_b     = ps_b + pd_b;
  assign alpha_mix = s3.a + div255(pd_a);

  always_comb begin
    if (transp3) begin
      pix_next = s3.dst;
    end else if (copy3) begin
      pix_next = {s3.a, s3.r, s3.g, s3.b};
    end else begin
      pix_next = {alpha_mix, div255(sum_r), div255(sum_g), div255(sum_b)};
    end
  end

  // stage 4: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ready4) begin
      v4 <= v3;
    end
    if (ready4 && v3) begin
      out_pixel    <= pix_next;
      write_enable <= !transp3;
    end
  end

  assign out_valid = v4;

endmodule

`default_nettype wire

>>> hw/rtl/argb_blend_with_color_mod_unit.sv
// argb_blend_with_color_mod_unit: top level of the ARGB8888 modulate and
// source-over blend pipeline. Depends on abcm_pkg, abcm_if, abcm_scale, abcm_mix.
//
//   channel | dir | payload                     | handshake
//   --------+-----+-----------------------------+-------------
//   pix     | in  | src_pixel[31:0], dst_pixel  | valid/ready
//   res     | out | out_pixel[31:0], write_enable | valid/ready
//   cfg     | in  | index[2:0], data[7:0]       | valid/ready
//
// One pixel request per clock while res.ready is high; each request passes
// multiply, divide by 255, mix multiply, mix sum/divide + output register.
// The four register stages carry their own valid bits; a low res.ready
// holds each full stage and backs up to pix.ready without dropping data.
// rst is synchronous: clears valids and loads the modulation registers to
// 255 and blend off. cfg is always ready; writes to unknown indexes are dropped.
`default_nettype none

module argb_blend_with_color_mod_unit (
  input wire logic  clk,
  input wire logic  rst,
  abcm_pix_if.sink  pix,
  abcm_cfg_if.sink  cfg,
  abcm_out_if.source res
);
  import abcm_pkg::*;

  mod_t    mods;
  logic    mid_valid;
  logic    mid_ready;
  scaled_t mid_data;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mods.red   <= CH_MAX;
      mods.green <= CH_MAX;
      mods.blue  <= CH_MAX;
      mods.alpha <= CH_MAX;
      mods.blend <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MOD_RED:   mods.red   <= cfg.data;
        REG_MOD_GREEN: mods.green <= cfg.data;
        REG_MOD_BLUE:  mods.blue  <= cfg.data;
        REG_MOD_ALPHA: mods.alpha <= cfg.data;
        REG_BLEND_EN:  mods.blend <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // stages 1-2: source modulation
  abcm_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .src_pixel (pix.src_pixel),
    .dst_pixel (pix.dst_pixel),
    .mods      (mods),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  // stages 3-4: blend and output register
  abcm_mix u_mix (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (mid_valid),
    .in_ready     (mid_ready),
    .in_data      (mid_data),
    .blend        (mods.blend),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .out_pixel    (res.out_pixel),
    .write_enable (res.write_enable)
  );

endmodule

`default_nettype wire

>>> hw/rtl/abcm_checker.sv
// abcm_checker: port-level checks for argb_blend_with_color_mod_unit,
// bound to the top level below. Depends on the top level's ports only.
`default_nettype none

module abcm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_pixel
);

  logic in_acc;
  logic out_acc;
  logic [2:0] inflight;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests inside the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 3'd0;
    end else begin
      inflight <= inflight + {2'd0, in_acc} - {2'd0, out_acc};
    end
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != 3'd0)
    else $error("result without a pending request");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'd4)
    else $error("more than four requests in flight");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing four cycles after accept");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel))
    else $error("stalled result changed");

endmodule

bind argb_blend_with_color_mod_unit abcm_checker u_abcm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix.valid),
  .in_ready  (pix.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_pixel (res.out_pixel)
);

`default_nettype wire

>>> test/argb_blend_with_color_mod_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for argb_blend_with_color_mod_unit: a directed table, then random pixel phases,
// each checked against a behavioral blend predictor. Depends on abcm_pkg and the abcm channel
// interfaces.

module argb_blend_with_color_mod_unit_tb;
  import abcm_pkg::*;

  // register stages from accept to result, as in the unit's header
  localparam int PIPE_LAT      = 4;
  localparam int NUM_PHASES    = 8;
  localparam int PIX_PER_PHASE = 54;
  localparam int DIR_ROWS      = 25;
  localparam int TIMEOUT_NS    = 200000;

  // index with no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

  // one result: new destination pixel plus write flag
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             we;
  } px_result_t;

  // directed row: either a config write (idx/data) or a pixel request, with an optional
  // hand-typed expectation
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CH_W-1:0]      data;
    logic [PIX_W-1:0]     src;
    logic [PIX_W-1:0]     dst;
    logic                 typed;
    logic [PIX_W-1:0]     exp_pix;
    logic                 exp_we;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  abcm_pix_if pix_ch ();
  abcm_cfg_if cfg_ch ();
  abcm_out_if res_ch ();

  argb_blend_with_color_mod_unit DUT (
    .clk (clk),
    .rst (rst),
    .pix (pix_ch),
    .cfg (cfg_ch),
    .res (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the modulation / blend registers, reset values
  mod_t cur_mod = '{red: CH_MAX, green: CH_MAX, blue: CH_MAX, alpha: CH_MAX, blend: 1'b0};

  px_result_t pending_px[$];   // expected results, oldest first
  px_result_t got_exp;

  // typed expectation riding along with the current pixel request
  logic       pix_typed = 1'b0;
  px_result_t typed_exp = '0;

  bit idle_on = 1'b1;          // random gaps / back-pressure enabled
  int stall_left = 0;
  int errors = 0;
  int n_pix = 0;
  int n_res = 0;
  int n_cfg = 0;
  int n_clear = 0;

  stim_row_t dir_tab [DIR_ROWS];

  // x*m/255, truncating
  function automatic logic [CH_W-1:0] mod_scale(input logic [CH_W-1:0] x,
                                                input logic [CH_W-1:0] m);
    logic [PROD_W-1:0] p;
    p = x * m;
    return CH_W'(p / CH_MAX);
  endfunction

  // (s*a + d*(255-a))/255 for one color channel
  function automatic logic [CH_W-1:0] mix_ch(input logic [CH_W-1:0] s, input logic [CH_W-1:0] d,
                                             input logic [CH_W-1:0] a);
    logic [PROD_W-1:0] acc;
    acc = s * a + d * (CH_MAX - a);
    return CH_W'(acc / CH_MAX);
  endfunction

  // expected result of one pixel under the current register settings
  function automatic px_result_t predict_px(input logic [PIX_W-1:0] src,
                                            input logic [PIX_W-1:0] dst);
    logic [CH_W-1:0]   sa, sr, sg, sb, inv;
    logic [PROD_W-1:0] da_part;
    px_result_t        r;
    sa = mod_scale(src[31:24], cur_mod.alpha);
    sr = mod_scale(src[23:16], cur_mod.red);
    sg = mod_scale(src[15:8],  cur_mod.green);
    sb = mod_scale(src[7:0],   cur_mod.blue);
    if (sa == '0) begin
      // fully transparent after modulation: destination left alone
      r.pix = dst;
      r.we  = 1'b0;
    end else if (!cur_mod.blend || sa == CH_MAX) begin
      r.pix = {sa, sr, sg, sb};
      r.we  = 1'b1;
    end else begin
      inv     = CH_MAX - sa;
      da_part = dst[31:24] * inv;
      r.pix[31:24] = sa + CH_W'(da_part / CH_MAX);
      r.pix[23:16] = mix_ch(sr, dst[23:16], sa);
      r.pix[15:8]  = mix_ch(sg, dst[15:8],  sa);
      r.pix[7:0]   = mix_ch(sb, dst[7:0],   sa);
      r.we         = 1'b1;
    end
    return r;
  endfunction

  // modulation factor for random phases, leaning toward the extremes
  function automatic logic [CH_W-1:0] rand_factor();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CH_MAX;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Scoreboard: results checked at the rising edge, then config writes and new pixel
  // requests folded in. Config only moves while the pipe is empty, so ordering between
  // the two never matters.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        n_res++;
        if (pending_px.size() == 0) begin
          $display("%0t: result with nothing expected: pix %h we %b", $time,
                   res_ch.out_pixel, res_ch.write_enable);
          errors++;
        end else begin
          got_exp = pending_px.pop_front();
          if (res_ch.out_pixel !== got_exp.pix) begin
            $display("%0t: out_pixel mismatch: expected %h, actual %h", $time,
                     got_exp.pix, res_ch.out_pixel);
            errors++;
          end
          if (res_ch.write_enable !== got_exp.we) begin
            $display("%0t: write_enable mismatch: expected %b, actual %b", $time,
                     got_exp.we, res_ch.write_enable);
            errors++;
          end
          if (!got_exp.we) n_clear++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        n_cfg++;
        case (cfg_ch.index)
          REG_MOD_RED:   cur_mod.red   = cfg_ch.data;
          REG_MOD_GREEN: cur_mod.green = cfg_ch.data;
          REG_MOD_BLUE:  cur_mod.blue  = cfg_ch.data;
          REG_MOD_ALPHA: cur_mod.alpha = cfg_ch.data;
          REG_BLEND_EN:  cur_mod.blend = cfg_ch.data[0];
          default: ;  // unmapped index, dropped
        endcase
      end
      if (pix_ch.valid && pix_ch.ready) begin
        n_pix++;
        pending_px.push_back(pix_typed ? typed_exp
                                       : predict_px(pix_ch.src_pixel, pix_ch.dst_pixel));
      end
    end
  end

  // Result back-pressure: stall bursts of random length while idling is on.
  always @(negedge clk) begin
    if (!idle_on) begin
      res_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 5);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Drive one pixel request at the falling edge, optionally after a gap burst, and hold it
  // until accepted. valid stays high on return so back-to-back requests stream.
  task automatic send_pixel(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst,
                            input logic typed, input logic [PIX_W-1:0] ep, input logic ew);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
    @(negedge clk);
    repeat (gap) begin
      pix_ch.valid = 1'b0;
      @(negedge clk);
    end
    pix_ch.valid     = 1'b1;
    pix_ch.src_pixel = src;
    pix_ch.dst_pixel = dst;
    pix_typed        = typed;
    typed_exp        = '{pix: ep, we: ew};
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // stop the pixel stream and wait until every expected result is back
  task automatic wait_pipeline_empty();
    @(negedge clk);
    pix_ch.valid = 1'b0;
    wait (pending_px.size() == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CH_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin
    mod_t      next_mod;
    logic [31:0] rnd;
    logic [7:0]  alpha;

    pix_ch.valid     = 1'b0;
    pix_ch.src_pixel = '0;
    pix_ch.dst_pixel = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    res_ch.ready     = 1'b1;

    // Directed table. Typed expectations only where the answer is obvious:
    // reset settings (plain copy), opaque source, transparent source.
    dir_tab = '{
      // reset: copy mode, factors 255
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF, 1'b1},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'h00123456, 32'hDEADBEEF, 1'b1, 32'hDEADBEEF, 1'b0},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'h01000000, 32'hFFFFFFFF, 1'b1, 32'h01000000, 1'b1},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'h80FF00FF, 32'h12345678, 1'b1, 32'h80FF00FF, 1'b1},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'h00FFFFFF, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
      // blending on: opaque source still copies, partial alpha mixes
      '{ROW_CFG, REG_BLEND_EN, 8'h01, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'hFFA5A5A5, 32'h00000000, 1'b1, 32'hFFA5A5A5, 1'b1},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'h80FF8000, 32'h40204060, 1'b0, 32'h0, 1'b0},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'h01FFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'hFE000000, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'h00FFFFFF, 32'h13579BDF, 1'b1, 32'h13579BDF, 1'b0},
      // alpha factor 128: alpha 1 rounds down to transparent, 255 becomes a mix
      '{ROW_CFG, REG_MOD_ALPHA, 8'h80, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'h01FFFFFF, 32'hAABBCCDD, 1'b0, 32'h0, 1'b0},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'hFF804020, 32'h11223344, 1'b0, 32'h0, 1'b0},
      // color factors at 0x00, mid (0x7F) and 0x01
      '{ROW_CFG, REG_MOD_RED, 8'h00, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{ROW_CFG, REG_MOD_GREEN, 8'h7F, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{ROW_CFG, REG_MOD_BLUE, 8'h01, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'hFFFFFFFF, 32'h00000000, 1'b0, 32'h0, 1'b0},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
      // write to an unmapped index must leave the settings alone
      '{ROW_CFG, REG_UNMAPPED, 8'h00, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'hFFFFFFFF, 32'h00000000, 1'b0, 32'h0, 1'b0},
      // blend enable keeps bit 0 only: 0xFE turns blending off
      '{ROW_CFG, REG_BLEND_EN, 8'hFE, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'hFF8080FF, 32'h55AA55AA, 1'b0, 32'h0, 1'b0},
      // alpha factor 0 makes everything transparent
      '{ROW_CFG, REG_MOD_ALPHA, 8'h00, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{ROW_PIX, REG_UNMAPPED, 8'h00, 32'hFFFFFFFF, 32'hCAFEF00D, 1'b1, 32'hCAFEF00D, 1'b0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_pipeline_empty();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_pixel(dir_tab[i].src, dir_tab[i].dst, dir_tab[i].typed,
                   dir_tab[i].exp_pix, dir_tab[i].exp_we);
      end
    end

    // Random phases: new register settings each phase (extremes first), then a run of
    // pixels with alpha biased toward 0, 1, 254 and 255. The last phase runs with no
    // gaps and no stalls at full rate, as does one phase in the middle.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: next_mod = '{red: CH_MAX, green: CH_MAX, blue: CH_MAX, alpha: CH_MAX, blend: 1'b1};
        1: next_mod = '{red: '0, green: '0, blue: '0, alpha: CH_MAX, blend: 1'b1};
        2: next_mod = '{red: CH_MAX, green: CH_MAX, blue: CH_MAX, alpha: '0, blend: 1'b0};
        default: begin
          next_mod.red   = rand_factor();
          next_mod.green = rand_factor();
          next_mod.blue  = rand_factor();
          next_mod.alpha = rand_factor();
          next_mod.blend = ($urandom_range(0, 3) != 0);
        end
      endcase
      wait_pipeline_empty();
      idle_on = (ph != 4) && (ph != NUM_PHASES - 1);
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(5, 7)), CH_W'($urandom));
      write_reg(REG_MOD_RED,   next_mod.red);
      write_reg(REG_MOD_GREEN, next_mod.green);
      write_reg(REG_MOD_BLUE,  next_mod.blue);
      write_reg(REG_MOD_ALPHA, next_mod.alpha);
      // upper data bits random; only bit 0 counts
      write_reg(REG_BLEND_EN,  {7'($urandom), next_mod.blend});

      for (int n = 0; n < PIX_PER_PHASE; n++) begin
        case ($urandom_range(0, 7))
          0: alpha = 8'h00;
          1: alpha = 8'hFF;
          2: alpha = 8'h01;
          3: alpha = 8'hFE;
          default: alpha = 8'($urandom_range(0, 255));
        endcase
        rnd = $urandom;
        send_pixel({alpha, rnd[23:0]}, $urandom, 1'b0, '0, 1'b0);
      end
    end

    wait_pipeline_empty();
    // extra cycles to catch any stray result after the last one
    repeat (2 * PIPE_LAT) @(posedge clk);

    $display("Run: %0d pixel requests, %0d results (%0d transparent), %0d config writes.",
             n_pix, n_res, n_clear, n_cfg);
    $display("Settings swept: factors 0/255/random, blend on and off, unmapped index writes.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d results still outstanding", pending_px.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/abcm_pkg.sv
hw/rtl/abcm_if.sv
hw/rtl/abcm_scale.sv
hw/rtl/abcm_mix.sv
hw/rtl/argb_blend_with_color_mod_unit.sv
hw/rtl/abcm_checker.sv
test/argb_blend_with_color_mod_unit_tb.sv
